@@ rtl/ttbd_pkg.sv @@
// Package for the tabular text block deframer: parse phases, event codes,
// header layout constants and the result item type. No dependencies.
package ttbd_pkg;

   // Last header byte position that is skipped is HEADER_END + 1.
   localparam int unsigned HEADER_END = 128;

   localparam logic [31:0] POS_DIV_LAST   = 32'd1;
   localparam logic [31:0] POS_BID_LAST   = 32'd3;
   localparam logic [31:0] POS_LEN_LAST   = 32'd7;
   localparam logic [31:0] POS_SKIP_LAST  = 32'(HEADER_END + 1);
   localparam logic [31:0] POS_PAGES_LAST = 32'(HEADER_END + 3);

   localparam logic [15:0] DIVIDER_WORD = 16'hFFFF;
   localparam logic [15:0] BLOCK_ID     = 16'd3;
   localparam logic [15:0] PAGE_END_LEN = 16'hFFFF;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_DIV   = 4'd1,
      PH_BID   = 4'd2,
      PH_LEN   = 4'd3,
      PH_SKIP  = 4'd4,
      PH_PAGES = 4'd5,
      PH_LHI   = 4'd6,
      PH_LLO   = 4'd7,
      PH_TEXT  = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      EV_TEXT     = 3'd0,
      EV_EMPTY    = 3'd1,
      EV_PAGE_END = 3'd2,
      EV_BAD_DIV  = 3'd3,
      EV_BAD_ID   = 3'd4,
      EV_BAD_LEN  = 3'd5,
      EV_DONE     = 3'd6
   } event_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [7:0]  text_byte;
      logic [15:0] page_number;
      logic        line_end;
   } rsp_item_type;

endpackage

@@ rtl/ttbd_req_if.sv @@
// Input channel of the deframer: one raw block byte and its start flag.
// Standalone; no package needed.
interface ttbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       block_start;

   modport source(output valid, data_byte, block_start, input ready);
   modport sink(input valid, data_byte, block_start, output ready);
endinterface

@@ rtl/ttbd_rsp_if.sv @@
// Result channel of the deframer: one event with text byte, page and line end.
// Standalone; no package needed.
interface ttbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [7:0]  text_byte;
   logic [15:0] page_number;
   logic        line_end;

   modport source(output valid, event_kind, text_byte, page_number, line_end,
                  input ready);
   modport sink(input valid, event_kind, text_byte, page_number, line_end,
                output ready);
endinterface

@@ rtl/ttbd_parser.sv @@
// Parse state machine and counters of the deframer; one byte per step.
// Depends on ttbd_pkg.
module ttbd_parser import ttbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   data_byte,
   input  logic         block_start,
   output logic         fire,
   output rsp_item_type item
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [31:0] pos_ff, pos_in, pos_cur;
   logic [31:0] blen_ff, blen_in;
   logic [31:0] shift_ff, shift_in, shift_cur, shift_next;
   logic [15:0] ptotal_ff, ptotal_in;
   logic [15:0] pidx_ff, pidx_in, pidx_cur;
   logic [14:0] lrem_ff, lrem_in, lrem_dec;
   logic [15:0] half_word;
   logic [15:0] line_len;
   logic        more;

   // A start byte restarts the parser at position zero of the divider.
   always_comb begin
      phase_cur  = block_start ? PH_DIV : phase_ff;
      pos_cur    = block_start ? '0 : pos_ff;
      shift_cur  = block_start ? '0 : shift_ff;
      pidx_cur   = block_start ? '0 : pidx_ff;
      shift_next = {shift_cur[23:0], data_byte};
      half_word  = shift_next[15:0];
      line_len   = {shift_cur[7:0], data_byte};
      lrem_dec   = lrem_ff - 15'd1;
      more       = !ptotal_ff[15] && (pidx_cur < ptotal_ff) &&
                   !blen_ff[31] && (pos_cur < blen_ff);
   end

   // Next state and next counter values
   always_comb begin
      phase_in  = phase_cur;
      pos_in    = pos_cur + 32'd1;
      blen_in   = blen_ff;
      shift_in  = shift_cur;
      ptotal_in = ptotal_ff;
      pidx_in   = pidx_cur;
      lrem_in   = lrem_ff;
      case (phase_cur)
         PH_IDLE: begin
            pos_in = pos_ff;
         end
         PH_DIV: begin
            shift_in = {16'd0, half_word};
            if (pos_cur == POS_DIV_LAST) begin
               if (half_word == DIVIDER_WORD) begin
                  shift_in = '0;
                  phase_in = PH_BID;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_BID: begin
            shift_in = {16'd0, half_word};
            if (pos_cur == POS_BID_LAST) begin
               if (half_word == BLOCK_ID) begin
                  shift_in = '0;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_LEN: begin
            shift_in = shift_next;
            if (pos_cur == POS_LEN_LAST) begin
               blen_in  = shift_next;
               shift_in = '0;
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            if (pos_cur == POS_SKIP_LAST) begin
               phase_in = PH_PAGES;
            end
         end
         PH_PAGES: begin
            shift_in = {16'd0, half_word};
            if (pos_cur == POS_PAGES_LAST) begin
               ptotal_in = half_word;
               shift_in  = '0;
               phase_in  = PH_LHI;
            end
         end
         PH_LHI: begin
            if (more) begin
               shift_in = {24'd0, data_byte};
               phase_in = PH_LLO;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_LLO: begin
            shift_in = '0;
            if (line_len == PAGE_END_LEN) begin
               pidx_in  = pidx_cur + 16'd1;
               phase_in = PH_LHI;
            end else if (line_len[15]) begin
               phase_in = PH_IDLE;
            end else if (line_len == 16'd0) begin
               phase_in = PH_LHI;
            end else begin
               lrem_in  = line_len[14:0];
               phase_in = PH_TEXT;
            end
         end
         PH_TEXT: begin
            lrem_in = lrem_dec;
            if (lrem_dec == 15'd0) begin
               phase_in = PH_LHI;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Event outputs
   always_comb begin
      fire             = 1'b0;
      item.event_kind  = EV_TEXT;
      item.text_byte   = '0;
      item.page_number = pidx_cur;
      item.line_end    = 1'b0;
      case (phase_cur)
         PH_DIV: begin
            if (pos_cur == POS_DIV_LAST && half_word != DIVIDER_WORD) begin
               fire            = 1'b1;
               item.event_kind = EV_BAD_DIV;
            end
         end
         PH_BID: begin
            if (pos_cur == POS_BID_LAST && half_word != BLOCK_ID) begin
               fire            = 1'b1;
               item.event_kind = EV_BAD_ID;
            end
         end
         PH_LHI: begin
            if (!more) begin
               fire            = 1'b1;
               item.event_kind = EV_DONE;
            end
         end
         PH_LLO: begin
            fire = 1'b1;
            if (line_len == PAGE_END_LEN) begin
               item.event_kind = EV_PAGE_END;
            end else if (line_len[15]) begin
               item.event_kind = EV_BAD_LEN;
            end else if (line_len == 16'd0) begin
               item.event_kind = EV_EMPTY;
            end else begin
               fire = 1'b0;
            end
         end
         PH_TEXT: begin
            fire           = 1'b1;
            item.text_byte = data_byte;
            item.line_end  = (lrem_dec == 15'd0);
         end
         default: begin
            fire = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         blen_ff   <= '0;
         shift_ff  <= '0;
         ptotal_ff <= '0;
         pidx_ff   <= '0;
         lrem_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         blen_ff   <= blen_in;
         shift_ff  <= shift_in;
         ptotal_ff <= ptotal_in;
         pidx_ff   <= pidx_in;
         lrem_ff   <= lrem_in;
      end
   end

endmodule

@@ rtl/ttbd_out_stage.sv @@
// Result register of the deframer: holds one event until the sink takes it.
// Depends on ttbd_pkg.
module ttbd_out_stage import ttbd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   output logic         can_load,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // Free when empty or when the held event leaves this cycle.
   assign can_load  = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

@@ rtl/tabular_text_block_deframer.sv @@
// Tabular text block deframer: one block byte in per transfer, at most one event out.
// Latency: an event is offered on rsp_chan the cycle after the byte's transfer.
// Throughput: one byte per cycle; the parser state updates in the transfer cycle.
// The result register decouples the sides; req_chan stalls only while it is full and held.
// Reset (synchronous, active high): parser idle waiting for a start byte, all counters
// cleared, result register empty. Depends on ttbd_pkg, ttbd_req_if, ttbd_rsp_if.
module tabular_text_block_deframer import ttbd_pkg::*; (
   input logic       clock,
   input logic       reset,
   ttbd_req_if.sink   req_chan,
   ttbd_rsp_if.source rsp_chan
);

   logic         req_xfer;    // input transfer this cycle
   logic         ev_fire;     // the byte produces an event
   logic         stage_free;
   rsp_item_type ev_item;
   rsp_item_type held_item;

   assign req_chan.ready = stage_free;
   assign req_xfer       = req_chan.valid && stage_free;

   // Byte parser: divider, block id, length, header skip, page count, lines.
   ttbd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (req_xfer),
      .data_byte   (req_chan.data_byte),
      .block_start (req_chan.block_start),
      .fire        (ev_fire),
      .item        (ev_item)
   );

   // Result register; only bytes that produce an event load it.
   ttbd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_xfer && ev_fire),
      .load_item (ev_item),
      .can_load  (stage_free),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (held_item)
   );

   assign rsp_chan.event_kind  = held_item.event_kind;
   assign rsp_chan.text_byte   = held_item.text_byte;
   assign rsp_chan.page_number = held_item.page_number;
   assign rsp_chan.line_end    = held_item.line_end;

endmodule

@@ bench/ttbd_event_checker.sv @@
// Event checker for the tabular text block deframer: watches both channels,
// predicts each event from the accepted bytes and compares it field by field.
// Depends on ttbd_pkg, ttbd_req_if and ttbd_rsp_if.
module ttbd_event_checker import ttbd_pkg::*; (
   input  logic clock,
   input  logic reset,
   ttbd_req_if  req_mon,
   ttbd_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   events_pending
);

   phase_type    stage;
   logic [31:0]  byte_pos;
   logic [31:0]  frame_len;
   logic [31:0]  gather;
   logic [15:0]  pages_total;
   logic [15:0]  page_at;
   logic [14:0]  chars_left;
   int           mismatches = 0;
   rsp_item_type expected_events[$];

   assign mismatch_count = mismatches;

   function automatic rsp_item_type make_event(event_type kind, logic [7:0] ch, logic eol);
      rsp_item_type e;
      e.event_kind  = kind;
      e.text_byte   = ch;
      e.page_number = page_at;
      e.line_end    = eol;
      return e;
   endfunction

   function automatic void clear_parser();
      stage       = PH_IDLE;
      byte_pos    = '0;
      frame_len   = '0;
      gather      = '0;
      pages_total = '0;
      page_at     = '0;
      chars_left  = '0;
   endfunction

   // One byte through the deframer state; at most one event comes out.
   task automatic deframe_byte(input logic [7:0] b, input logic first,
                               output bit has_event, output rsp_item_type ev);
      logic [31:0] here;
      logic [15:0] len_word;
      bit          pages_left;
      bit          bytes_left;
      has_event = 0;
      ev = '0;
      if (first) begin
         clear_parser();
         stage = PH_DIV;
      end
      if (stage != PH_IDLE) begin
         here = byte_pos;
         case (stage)
            PH_DIV: begin
               gather = {16'h0, gather[7:0], b};
               if (here == POS_DIV_LAST) begin
                  if (gather[15:0] != DIVIDER_WORD) begin
                     ev = make_event(EV_BAD_DIV, 8'h00, 1'b0);
                     has_event = 1;
                     stage = PH_IDLE;
                  end else begin
                     gather = '0;
                     stage = PH_BID;
                  end
               end
            end
            PH_BID: begin
               gather = {16'h0, gather[7:0], b};
               if (here == POS_BID_LAST) begin
                  if (gather[15:0] != BLOCK_ID) begin
                     ev = make_event(EV_BAD_ID, 8'h00, 1'b0);
                     has_event = 1;
                     stage = PH_IDLE;
                  end else begin
                     gather = '0;
                     stage = PH_LEN;
                  end
               end
            end
            PH_LEN: begin
               gather = {gather[23:0], b};
               if (here == POS_LEN_LAST) begin
                  frame_len = gather;
                  gather = '0;
                  stage = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (here == POS_SKIP_LAST) stage = PH_PAGES;
            end
            PH_PAGES: begin
               gather = {16'h0, gather[7:0], b};
               if (here == POS_PAGES_LAST) begin
                  pages_total = gather[15:0];
                  gather = '0;
                  stage = PH_LHI;
               end
            end
            PH_LHI: begin
               // both counts are signed: a negative total ends the block at once
               pages_left = !pages_total[15] && (page_at < pages_total);
               bytes_left = !frame_len[31] && (byte_pos < frame_len);
               if (!(pages_left && bytes_left)) begin
                  ev = make_event(EV_DONE, 8'h00, 1'b0);
                  has_event = 1;
                  stage = PH_IDLE;
               end else begin
                  gather = {24'h0, b};
                  stage = PH_LLO;
               end
            end
            PH_LLO: begin
               len_word = {gather[7:0], b};
               gather = '0;
               if (len_word == PAGE_END_LEN) begin
                  ev = make_event(EV_PAGE_END, 8'h00, 1'b0);
                  has_event = 1;
                  page_at = page_at + 16'd1;
                  stage = PH_LHI;
               end else if (len_word[15]) begin
                  ev = make_event(EV_BAD_LEN, 8'h00, 1'b0);
                  has_event = 1;
                  stage = PH_IDLE;
               end else if (len_word == 16'h0) begin
                  ev = make_event(EV_EMPTY, 8'h00, 1'b0);
                  has_event = 1;
                  stage = PH_LHI;
               end else begin
                  chars_left = len_word[14:0];
                  stage = PH_TEXT;
               end
            end
            PH_TEXT: begin
               chars_left = chars_left - 15'd1;
               ev = make_event(EV_TEXT, b, chars_left == 15'd0);
               has_event = 1;
               if (chars_left == 15'd0) stage = PH_LHI;
            end
            default: stage = PH_IDLE;
         endcase
         byte_pos = here + 32'd1;
      end
   endtask

   always @(posedge clock) begin : watch
      bit           has_event;
      rsp_item_type ev;
      rsp_item_type seen;
      rsp_item_type want;
      if (reset) begin
         expected_events.delete();
         clear_parser();
      end else begin
         // results first: an event never leaves in the cycle of its own byte
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.event_kind  = rsp_mon.event_kind;
            seen.text_byte   = rsp_mon.text_byte;
            seen.page_number = rsp_mon.page_number;
            seen.line_end    = rsp_mon.line_end;
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d, byte %0d, page %0d, line end %0d",
                      seen.event_kind, seen.text_byte, seen.page_number, seen.line_end);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               if (seen.event_kind != want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d",
                         want.event_kind, seen.event_kind);
                  mismatches++;
               end
               if (seen.text_byte != want.text_byte) begin
                  $error("text_byte: expected %0d, actual %0d",
                         want.text_byte, seen.text_byte);
                  mismatches++;
               end
               if (seen.page_number != want.page_number) begin
                  $error("page_number: expected %0d, actual %0d",
                         want.page_number, seen.page_number);
                  mismatches++;
               end
               if (seen.line_end != want.line_end) begin
                  $error("line_end: expected %0d, actual %0d",
                         want.line_end, seen.line_end);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            deframe_byte(req_mon.data_byte, req_mon.block_start, has_event, ev);
            if (has_event) expected_events.push_back(ev);
         end
      end
      events_pending <= expected_events.size();
   end

endmodule

@@ bench/testbench.sv @@
// Top of the deframer bench: clock, reset, byte stimulus, result back-pressure
// and the verdict. Depends on ttbd_pkg, both channel interfaces and ttbd_event_checker.
module testbench import ttbd_pkg::*; ();

   // stop once this many block bytes have gone in
   localparam int TARGET_ITEMS = 1450;
   // cycles without any transfer before the run is declared hung
   localparam int QUIET_LIMIT  = 4000;
   // one long receiver hold-off, in cycles, to fill the block and stall input
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 40;

   // how the block length field relates to the real block size
   localparam int LEN_EXACT    = 0;
   localparam int LEN_LONGER   = 1;
   localparam int LEN_SHORTER  = 2;
   localparam int LEN_NEGATIVE = 3;
   localparam int LEN_MAX      = 4;
   localparam int LEN_ZERO     = 5;

   // how the page count relates to the pages actually written
   localparam int PAGES_EXACT    = 0;
   localparam int PAGES_MORE     = 1;
   localparam int PAGES_FEWER    = 2;
   localparam int PAGES_NEGATIVE = 3;

   // what ends the frame
   localparam int TAIL_CLEAN      = 0;
   localparam int TAIL_BAD_LENGTH = 1;
   localparam int TAIL_RUNAWAY    = 2;
   localparam int TAIL_CUT        = 3;

   logic clock;
   logic reset;
   int   mismatches;
   int   events_pending;
   int   block_items = 0;
   bit   sender_calm = 0;
   logic [7:0] frame_bytes[$];

   ttbd_req_if req_chan();
   ttbd_rsp_if rsp_chan();

   tabular_text_block_deframer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   ttbd_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatches),
      .events_pending (events_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every input known from time zero; reset held high once, at the start.
   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = 8'h00;
      req_chan.block_start = 1'b0;
      rsp_chan.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Big-endian halfword onto the frame under construction.
   function automatic void put_half(logic [15:0] v);
      frame_bytes.push_back(v[15:8]);
      frame_bytes.push_back(v[7:0]);
   endfunction

   // One byte transfer. The gap is drawn per byte; valid stays up across
   // back-to-back bytes so it never drops and rises in the same step.
   task automatic send_byte(input logic [7:0] d, input logic first);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= d;
      req_chan.block_start <= first;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // The frame goes out with the start flag on its first byte only.
   task automatic send_frame();
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i], i == 0);
         block_items++;
      end
   endtask

   // Full tabular block: divider, id, length, skipped header, page count,
   // then pages of length-prefixed lines, each page closed by a -1 length.
   function automatic void build_block(int len_mode, int page_mode, int tail);
      int          n_pages;
      int          n_lines;
      int          n;
      int          full_size;
      int          cut;
      logic [31:0] len_val;
      logic [15:0] page_val;
      frame_bytes.delete();
      put_half(DIVIDER_WORD);
      put_half(BLOCK_ID);
      put_half(16'h0);
      put_half(16'h0);
      // positions 8 .. HEADER_END+1 are skipped by the parser; fill with junk
      repeat (HEADER_END - 6) frame_bytes.push_back(8'($urandom_range(0, 255)));
      put_half(16'h0);
      n_pages = $urandom_range(0, 3);
      for (int p = 0; p < n_pages; p++) begin
         n_lines = $urandom_range(0, 3);
         for (int l = 0; l < n_lines; l++) begin
            n = $urandom_range(0, 29);
            if (n < 4) n = 0;                                 // empty line
            else if (n == 29) n = $urandom_range(40, 120);    // a long one now and then
            else n = $urandom_range(1, 8);
            put_half(16'(n));
            repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
         end
         put_half(PAGE_END_LEN);
      end
      if (tail == TAIL_BAD_LENGTH) begin
         // negative length other than -1 kills the block; rest is ignored
         put_half(16'h8000 | 16'($urandom_range(0, 16'h7FFE)));
         repeat ($urandom_range(0, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (tail == TAIL_RUNAWAY) begin
         // max positive line length; only the next block start stops it
         put_half(16'h7FFF);
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      full_size = frame_bytes.size();
      // both trailing tails need the parser to still want more lines
      if (tail == TAIL_BAD_LENGTH || tail == TAIL_RUNAWAY) begin
         len_mode  = LEN_LONGER;
         page_mode = PAGES_MORE;
      end else if ((len_mode == LEN_LONGER || len_mode == LEN_MAX) &&
                   page_mode == PAGES_MORE) begin
         // nothing would end the block; keep it from eating the next frame
         page_mode = PAGES_EXACT;
      end
      case (len_mode)
         LEN_EXACT:    len_val = 32'(full_size);
         LEN_LONGER:   len_val = 32'(full_size + $urandom_range(1, 1000));
         LEN_SHORTER:  len_val = 32'($urandom_range(0, full_size - 1));
         LEN_NEGATIVE: len_val = 32'h8000_0000 | 32'($urandom);
         LEN_MAX:      len_val = 32'h7FFF_FFFF;
         default:      len_val = 32'h0;
      endcase
      case (page_mode)
         PAGES_EXACT: page_val = 16'(n_pages);
         PAGES_MORE:  page_val = ($urandom_range(0, 2) == 0) ? 16'h7FFF
                                 : 16'(n_pages + $urandom_range(1, 4));
         PAGES_FEWER: page_val = (n_pages > 0) ? 16'($urandom_range(0, n_pages - 1)) : 16'h0;
         default:     page_val = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      endcase
      frame_bytes[4]              = len_val[31:24];
      frame_bytes[5]              = len_val[23:16];
      frame_bytes[6]              = len_val[15:8];
      frame_bytes[7]              = len_val[7:0];
      frame_bytes[HEADER_END + 2] = page_val[15:8];
      frame_bytes[HEADER_END + 3] = page_val[7:0];
      if (tail == TAIL_CUT) begin
         // drop the end; the next start byte restarts mid-block
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
   endfunction

   // Stimulus: a short directed set, then blocks until the item target is met.
   initial begin : stimulus
      // first blocks walk through every length and page-count relation
      int forced_len[10]  = '{LEN_EXACT, LEN_LONGER, LEN_SHORTER, LEN_NEGATIVE, LEN_MAX,
                              LEN_ZERO, LEN_EXACT, LEN_LONGER, LEN_LONGER, LEN_EXACT};
      int forced_page[10] = '{PAGES_EXACT, PAGES_EXACT, PAGES_MORE, PAGES_EXACT,
                              PAGES_NEGATIVE, PAGES_EXACT, PAGES_MORE, PAGES_MORE,
                              PAGES_MORE, PAGES_FEWER};
      int forced_tail[10] = '{TAIL_CLEAN, TAIL_CLEAN, TAIL_CLEAN, TAIL_CLEAN, TAIL_CLEAN,
                              TAIL_CLEAN, TAIL_CLEAN, TAIL_BAD_LENGTH, TAIL_RUNAWAY,
                              TAIL_CUT};
      int          block_no;
      int          pick;
      int          tail;
      logic [31:0] word;
      do @(posedge clock); while (reset);

      // bytes with no start while idle produce nothing
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // divider errors: both bytes wrong, then only the low byte wrong
      frame_bytes = '{8'h00, 8'h00};
      send_frame();
      frame_bytes = '{8'hFF, 8'hFE};
      send_frame();
      // block id errors: zero, byte-swapped 3, all ones
      frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00};
      send_frame();
      frame_bytes = '{8'hFF, 8'hFF, 8'h03, 8'h00};
      send_frame();
      frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_frame();
      // restart in the middle of the block id
      frame_bytes = '{8'hFF, 8'hFF, 8'h00};
      send_frame();

      block_no = 0;
      while (block_items < TARGET_ITEMS) begin
         // some frames go through with no sender gaps at all
         sender_calm = ($urandom_range(0, 3) == 0);
         tail = TAIL_CLEAN;
         if (block_no < 10) begin
            tail = forced_tail[block_no];
            build_block(forced_len[block_no], forced_page[block_no], tail);
         end else begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               // broken header: bad divider or bad id
               frame_bytes.delete();
               tail = TAIL_CUT;
               if ($urandom_range(0, 1) == 0) begin
                  put_half(16'($urandom_range(0, 16'hFFFE)));
               end else begin
                  put_half(DIVIDER_WORD);
                  do word = $urandom; while (word[15:0] == BLOCK_ID);
                  put_half(word[15:0]);
               end
            end else if (pick == 2) begin
               tail = TAIL_BAD_LENGTH;
               build_block(LEN_LONGER, PAGES_MORE, tail);
            end else if (pick == 3) begin
               tail = TAIL_RUNAWAY;
               build_block(LEN_LONGER, PAGES_MORE, tail);
            end else if (pick == 4) begin
               tail = TAIL_CUT;
               build_block($urandom_range(0, 5), $urandom_range(0, 3), tail);
            end else begin
               build_block($urandom_range(0, 5), $urandom_range(0, 3), tail);
            end
         end
         send_frame();
         // a clean block not already ended by its counts reports done on the byte after it,
         // unless the next byte starts a new block; idle noise after done is ignored
         if (tail == TAIL_CLEAN && $urandom_range(0, 1) == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            block_items++;
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         end
         block_no++;
      end
      // close out whatever block is still open
      send_byte(8'($urandom_range(0, 255)), 1'b0);
      block_items++;
      req_chan.valid <= 1'b0;

      // drain, then a short settle for any stray event
      @(posedge clock);
      while (events_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Receiver: a random stall before each transfer, calm stretches with
   // ready held high, and one long hold-off so the result register fills
   // and the input side backs up.
   initial begin : receiver
      int  stall;
      int  taken;
      bit  calm;
      taken = 0;
      calm  = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % 48 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 12);
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   end

   // Watchdog: reset or any transfer on either side resets the quiet count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

endmodule
